/* sv/assert_macros.svh */
// Assertion macros used by the checker file kwm_checker.sv.
// Expects clk and rst_n (synchronous, active low) in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is held.
`define KWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that one condition implies another in the same cycle.
`define KWM_ASSERT_IMPL(label, cond, expr, msg) \
  `KWM_ASSERT(label, (cond) |-> (expr), msg)

`endif

/* sv/kwm_pkg.sv */
// Shared types and constants of the k-way sorted merge.
// No dependencies; imported by every module of the block.
package kwm_pkg;

  localparam int CFG_W  = 4;
  localparam int LANE_F_W = 3;
  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;

  localparam logic [CFG_W-1:0] CFG_LANES_RESET = 4'd8;

  localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic                    bad;      // lane outside the lanes in use
    logic [LANE_F_W-1:0]     lane;
    logic signed [VAL_W-1:0] value;
    logic                    is_end;
  } kwm_op_t;

endpackage

/* sv/kwm_front.sv */
// Front of the merge: accepts input beats, flags out-of-range lanes and
// buffers them in a two-entry queue. Depends on kwm_pkg.
module kwm_front
  import kwm_pkg::*;
#(
  parameter int CNT_W = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LANE_F_W-1:0]     in_lane,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_is_end,
  input  logic [CNT_W-1:0]        act_lanes,
  output logic                    q_valid,
  output kwm_op_t                 q_op,
  input  logic                    q_pop
);

  kwm_op_t     fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        pop;
  kwm_op_t     op_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != 2'd0);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = fifo_r[rd_ptr_r];

  always_comb begin
    op_in.bad    = (32'(in_lane) >= 32'(act_lanes));
    op_in.lane   = in_lane;
    op_in.value  = in_value;
    op_in.is_end = in_is_end;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

/* sv/kwm_back.sv */
// Back of the merge: lane head slots, end marks, minimum scan and the
// output register. Depends on kwm_pkg; fed by kwm_front.
module kwm_back
  import kwm_pkg::*;
#(
  parameter int LANES  = 8,
  parameter int LANE_W = 3,
  parameter int CNT_W  = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        act_lanes,
  input  logic                    q_valid,
  input  kwm_op_t                 q_op,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       out_kind,
  output logic signed [VAL_W-1:0] out_merged_value,
  output logic [LANE_F_W-1:0]     out_source_lane
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]              st_r, st_nxt;
  logic [LANES-1:0]        full_r, full_nxt;
  logic [LANES-1:0]        ended_r, ended_nxt;
  logic signed [VAL_W-1:0] heads_r [LANES];
  logic [LANE_W-1:0]       idx_r, idx_nxt;
  logic [LANE_W-1:0]       best_r, best_nxt;
  logic signed [VAL_W-1:0] bval_r, bval_nxt;
  logic                    found_r, found_nxt;
  logic [KIND_W-1:0]       res_kind_r, res_kind_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [LANE_F_W-1:0]     res_lane_r, res_lane_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [LANE_F_W-1:0]     out_lane_r;

  logic [LANES-1:0]        used;
  logic [LANE_W-1:0]       li;
  logic                    head_we;
  logic                    take;
  logic                    last;
  logic                    fin_found;
  logic [LANE_W-1:0]       fin_idx;
  logic signed [VAL_W-1:0] fin_val;
  logic                    out_load;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      used[i] = (i < int'(act_lanes));
    end
  end

  assign li        = LANE_W'(q_op.lane);
  assign take      = full_r[idx_r] && (!found_r || (heads_r[idx_r] < bval_r));
  assign last      = (idx_r == LANE_W'(act_lanes - 1'b1));
  assign fin_found = found_r || take;
  assign fin_idx   = take ? idx_r : best_r;
  assign fin_val   = take ? heads_r[idx_r] : bval_r;

  always_comb begin
    st_nxt       = st_r;
    full_nxt     = full_r;
    ended_nxt    = ended_r;
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    bval_nxt     = bval_r;
    found_nxt    = found_r;
    res_kind_nxt = res_kind_r;
    res_val_nxt  = res_val_r;
    res_lane_nxt = res_lane_r;
    q_pop        = 1'b0;
    head_we      = 1'b0;
    out_load     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op.bad || ended_r[li] || full_r[li]) begin
            res_kind_nxt = KIND_REJECT;
            res_val_nxt  = '0;
            res_lane_nxt = q_op.lane;
            st_nxt       = ST_EMIT;
          end else begin
            if (q_op.is_end) begin
              ended_nxt[li] = 1'b1;
            end else begin
              full_nxt[li] = 1'b1;
              head_we      = 1'b1;
            end
            // every lane in use is ready: start the minimum scan
            if (((full_nxt | ended_nxt) & used) == used) begin
              idx_nxt   = '0;
              found_nxt = 1'b0;
              st_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!last) begin
          idx_nxt   = idx_r + 1'b1;
          found_nxt = fin_found;
          best_nxt  = fin_idx;
          bval_nxt  = fin_val;
        end else begin
          if (fin_found) begin
            full_nxt[fin_idx] = 1'b0;
            res_kind_nxt      = KIND_VALUE;
            res_val_nxt       = fin_val;
            res_lane_nxt      = LANE_F_W'(fin_idx);
          end else begin
            // all lanes ended and drained: clear for the next merge
            full_nxt     = '0;
            ended_nxt    = '0;
            res_kind_nxt = KIND_DONE;
            res_val_nxt  = '0;
            res_lane_nxt = '0;
          end
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the result until the output register frees up
        out_load = !out_valid_r || !out_stall;
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      full_r      <= '0;
      ended_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      full_r      <= full_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    bval_r     <= bval_nxt;
    found_r    <= found_nxt;
    res_kind_r <= res_kind_nxt;
    res_val_r  <= res_val_nxt;
    res_lane_r <= res_lane_nxt;
    if (head_we) begin
      heads_r[li] <= q_op.value;
    end
    if (out_load) begin
      out_kind_r <= res_kind_r;
      out_val_r  <= res_val_r;
      out_lane_r <= res_lane_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_merged_value = out_val_r;
  assign out_source_lane  = out_lane_r;

endmodule

/* sv/k_way_sorted_merge_top.sv */
// Top level of the k-way sorted merge: lane count register, front queue
// and back merge engine. Depends on kwm_pkg, kwm_front and kwm_back.
//
// Usage:
//   Input beats (in_lane, in_value, in_is_end) each deliver the next value of
//   one lane or mark that lane ended. Once every lane in use holds a head or
//   has ended, the smallest head goes out with its lane (kind 0), lowest lane
//   on ties. Beats to a full slot, an ended lane or a lane outside the lanes
//   in use come back as kind 1. When all lanes have ended and drained, a
//   kind 2 beat is given and the merge state clears for the next run.
//   cfg_wr_en/cfg_wr_data set the lane count; write it only while idle.
// Flow:
//   A beat passes a two-entry queue, then the update state of the back end.
//   A beat that completes the lane set then runs the minimum scan, which
//   visits the head slots of the lanes in use one after another, and its
//   result goes through the emit state to the output register; a reject goes
//   to emit straight from the update state. The scan sets the sustained rate.
// Reset and stall:
//   Reset empties the queue, clears all slots and end marks and sets the lane
//   count to 8. A stalled result holds in the output register; the queue
//   keeps taking beats until it is full, then raises in_stall.
module k_way_sorted_merge_top
  import kwm_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LANE_F_W-1:0]     in_lane,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_is_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       out_kind,
  output logic signed [VAL_W-1:0] out_merged_value,
  output logic [LANE_F_W-1:0]     out_source_lane,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  localparam int LANE_W = $clog2(LANES);
  localparam int CNT_W  = $clog2(LANES + 1);

  logic [CFG_W-1:0] cfg_lanes_r, cfg_lanes_nxt;
  logic [CNT_W-1:0] act_lanes;
  logic             q_valid;
  kwm_op_t          q_op;
  logic             q_pop;

  assign cfg_lanes_nxt = cfg_wr_en ? cfg_wr_data : cfg_lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lanes_r <= CFG_LANES_RESET;
    end else begin
      cfg_lanes_r <= cfg_lanes_nxt;
    end
  end

  // Clamp the lane count to 1..LANES.
  always_comb begin
    if (cfg_lanes_r == '0) begin
      act_lanes = CNT_W'(1);
    end else if (32'(cfg_lanes_r) > LANES) begin
      act_lanes = CNT_W'(LANES);
    end else begin
      act_lanes = CNT_W'(cfg_lanes_r);
    end
  end

  kwm_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_lane   (in_lane),
    .in_value  (in_value),
    .in_is_end (in_is_end),
    .act_lanes (act_lanes),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop)
  );

  kwm_back #(
    .LANES  (LANES),
    .LANE_W (LANE_W),
    .CNT_W  (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .act_lanes        (act_lanes),
    .q_valid          (q_valid),
    .q_op             (q_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_merged_value (out_merged_value),
    .out_source_lane  (out_source_lane)
  );

endmodule

/* sv/kwm_checker.sv */
// Port-level checks of the merge result channel, bound to the top level.
// Depends on kwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kwm_checker
  import kwm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [KIND_W-1:0]       out_kind,
  input logic signed [VAL_W-1:0] out_merged_value,
  input logic [LANE_F_W-1:0]     out_source_lane
);

  `KWM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_merged_value) && $stable(out_source_lane), "stalled result changed")
  `KWM_ASSERT_IMPL(a_kind_legal, out_valid, out_kind == KIND_VALUE || out_kind == KIND_REJECT || out_kind == KIND_DONE, "illegal result kind")
  `KWM_ASSERT_IMPL(a_zero_value, out_valid && out_kind != KIND_VALUE, out_merged_value == '0, "non-value result carries a value")
  `KWM_ASSERT_IMPL(a_done_lane, out_valid && out_kind == KIND_DONE, out_source_lane == '0, "done result carries a lane")

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (.*);
